// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the local clock, off while reset is high
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen on a clock edge
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_PROP(label, !(expr), msg)

`endif

// ===== design/wrps_pkg.sv =====
package wrps_pkg;

   localparam int PROB_W      = 17;
   localparam int WEIGHT_W    = 16;
   localparam int TRANK_W     = 5;
   localparam int SCORE_W     = 32;
   localparam int RANKS_CFG_W = 5;
   localparam int TEAMS_CFG_W = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int RUN_W       = 21;
   localparam int MAG_W       = 21;
   localparam int SUM_W       = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_RANKS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_TEAMS = 1'd1;

   localparam logic [RANKS_CFG_W-1:0] NUM_RANKS_RESET = 5'd4;
   localparam logic [TEAMS_CFG_W-1:0] NUM_TEAMS_RESET = 9'd4;

   localparam logic [RUN_W-1:0] PROB_SAT = 21'h1FFFFF;
   localparam logic [RUN_W-1:0] ONE_Q16  = 21'h010000;

   typedef struct packed {
      logic [PROB_W-1:0]   prob;
      logic [WEIGHT_W-1:0] rank_weight;
      logic [TRANK_W-1:0]  team_rank;
   } req_item_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               status;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ,
      ST_LO,
      ST_HI,
      ST_ACC,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== design/wrps_stream_if.sv =====
interface wrps_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

// ===== design/weighted_rank_probability_score.sv =====
// Weighted rank probability score over a ranks-by-teams prediction matrix, fed column by
// column, one item per matrix element. Each row of a column other than the last takes the
// steps accept, square of the cumulative error, two 21x21 partial products with the row
// weight and saturating 64-bit accumulate; the square and both products share one 21x21
// multiplier, and req_ch.ready is low meanwhile. The last row of a column is only accepted.
// The last item of the matrix starts a one-bit-per-cycle restoring divide of the accumulator
// by (ranks-1)*teams, then loads the result register (with no divide when there is a single
// rank). The result sits in an output register, so new items are taken while it waits.
`include "assert_macros.svh"

module weighted_rank_probability_score
   import wrps_pkg::*;
#(
   parameter int MAX_RANKS = 16,
   parameter int MAX_TEAMS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   wrps_stream_if.sink            req_ch,
   wrps_stream_if.source          rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RW  = $clog2(MAX_RANKS + 1);
   localparam int RCW = $clog2(MAX_RANKS);
   localparam int TW  = $clog2(MAX_TEAMS + 1);
   localparam int TCW = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
   localparam int DW  = $clog2((MAX_RANKS - 1) * MAX_TEAMS + 1);
   localparam int DCW = $clog2(SUM_W);
   localparam int PW  = 2 * MAG_W;

   state_type state_ff, state_in;

   logic [RANKS_CFG_W-1:0] num_ranks_ff, num_ranks_in;
   logic [TEAMS_CFG_W-1:0] num_teams_ff, num_teams_in;
   logic [RCW-1:0]         row_count_ff, row_count_in;
   logic [TCW-1:0]         team_count_ff, team_count_in;
   logic [RUN_W-1:0]       running_prob_ff, running_prob_in;
   logic                   rank_reached_ff, rank_reached_in;
   logic [SUM_W-1:0]       score_sum_ff, score_sum_in;
   logic [TRANK_W-1:0]     max_rank_ff, max_rank_in;
   logic [DCW-1:0]         div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [PW-1:0]       sq_ff, sq_in;
   logic [PW-1:0]       lo_ff, lo_in;
   logic [PW-1:0]       hi_ff, hi_in;
   logic [SUM_W-1:0]    div_quo_ff, div_quo_in;
   logic [DW-1:0]       div_rem_ff, div_rem_in;
   logic [DW-1:0]       divisor_ff, divisor_in;
   logic                status_hold_ff, status_hold_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic [RW-1:0]    eff_r;
   logic [TW-1:0]    eff_t;
   logic             last_row;
   logic             last_team;
   logic             req_take;
   logic [RUN_W:0]   cum_raw;
   logic [RUN_W-1:0] cum_sat;
   logic             reached_next;
   logic [MAG_W-1:0] mag_next;
   logic [TRANK_W-1:0] max_rank_next;
   logic [MAG_W-1:0] mul_a;
   logic [MAG_W-1:0] mul_b;
   logic [PW-1:0]    mul_p;
   logic [SUM_W:0]   acc_sum;
   logic [DW:0]      rem_shift;
   logic             rem_ge;

   req_item_type req_item;

   assign req_item       = req_ch.payload;
   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign req_take       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_item_ff;

   // effective register values, clamped to the supported range
   always_comb begin
      if (num_ranks_ff == '0) begin
         eff_r = RW'(1);
      end else if (32'(num_ranks_ff) > MAX_RANKS) begin
         eff_r = RW'(MAX_RANKS);
      end else begin
         eff_r = RW'(num_ranks_ff);
      end
      if (num_teams_ff == '0) begin
         eff_t = TW'(1);
      end else if (32'(num_teams_ff) > MAX_TEAMS) begin
         eff_t = TW'(MAX_TEAMS);
      end else begin
         eff_t = TW'(num_teams_ff);
      end
   end

   assign last_row  = RW'(row_count_ff) >= (eff_r - RW'(1));
   assign last_team = TW'(team_count_ff) >= (eff_t - TW'(1));

   // cumulative probability and error magnitude of the incoming item
   always_comb begin
      cum_raw       = (RUN_W + 1)'(running_prob_ff) + (RUN_W + 1)'(req_item.prob);
      cum_sat       = cum_raw[RUN_W] ? PROB_SAT : cum_raw[RUN_W-1:0];
      reached_next  = rank_reached_ff ||
                      (32'(req_item.team_rank) == 32'(row_count_ff) + 32'd1);
      if (!reached_next) begin
         mag_next = cum_sat;
      end else if (cum_sat >= ONE_Q16) begin
         mag_next = cum_sat - ONE_Q16;
      end else begin
         mag_next = ONE_Q16 - cum_sat;
      end
      max_rank_next = (req_item.team_rank > max_rank_ff) ? req_item.team_rank : max_rank_ff;
   end

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_SQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         ST_LO: begin
            mul_a = sq_ff[MAG_W-1:0];
            mul_b = MAG_W'(weight_ff);
         end
         ST_HI: begin
            mul_a = sq_ff[PW-1:MAG_W];
            mul_b = MAG_W'(weight_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = PW'(mul_a) * PW'(mul_b);
   end

   assign acc_sum   = (SUM_W + 1)'(score_sum_ff) + ((SUM_W + 1)'(hi_ff) << MAG_W) +
                      (SUM_W + 1)'(lo_ff);
   assign rem_shift = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign rem_ge    = rem_shift >= (DW + 1)'(divisor_ff);

   always_comb begin
      state_in        = state_ff;
      num_ranks_in    = num_ranks_ff;
      num_teams_in    = num_teams_ff;
      row_count_in    = row_count_ff;
      team_count_in   = team_count_ff;
      running_prob_in = running_prob_ff;
      rank_reached_in = rank_reached_ff;
      score_sum_in    = score_sum_ff;
      max_rank_in     = max_rank_ff;
      div_cnt_in      = div_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      mag_in          = mag_ff;
      weight_in       = weight_ff;
      sq_in           = sq_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      div_quo_in      = div_quo_ff;
      div_rem_in      = div_rem_ff;
      divisor_in      = divisor_ff;
      status_hold_in  = status_hold_ff;
      rsp_item_in     = rsp_item_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_RANKS: num_ranks_in = csr_wdata[RANKS_CFG_W-1:0];
            CSR_NUM_TEAMS: num_teams_in = csr_wdata[TEAMS_CFG_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               max_rank_in = max_rank_next;
               if (!last_row) begin
                  running_prob_in = cum_sat;
                  rank_reached_in = reached_next;
                  mag_in          = mag_next;
                  weight_in       = req_item.rank_weight;
                  row_count_in    = row_count_ff + RCW'(1);
                  state_in        = ST_SQ;
               end else begin
                  row_count_in    = '0;
                  running_prob_in = '0;
                  rank_reached_in = 1'b0;
                  if (!last_team) begin
                     team_count_in = team_count_ff + TCW'(1);
                  end else begin
                     team_count_in  = '0;
                     score_sum_in   = '0;
                     max_rank_in    = '0;
                     status_hold_in = 32'(max_rank_next) != 32'(eff_r);
                     div_rem_in     = '0;
                     div_cnt_in     = '0;
                     divisor_in     = DW'(32'(eff_r - RW'(1)) * 32'(eff_t));
                     if (eff_r > RW'(1)) begin
                        div_quo_in = score_sum_ff;
                        state_in   = ST_DIV;
                     end else begin
                        div_quo_in = '0;
                        state_in   = ST_DONE;
                     end
                  end
               end
            end
         end
         ST_SQ: begin
            sq_in    = mul_p;
            state_in = ST_LO;
         end
         ST_LO: begin
            lo_in    = mul_p;
            state_in = ST_HI;
         end
         ST_HI: begin
            hi_in    = mul_p;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            score_sum_in = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
            state_in     = ST_IDLE;
         end
         ST_DIV: begin
            div_rem_in = rem_ge ? DW'(rem_shift - (DW + 1)'(divisor_ff)) : DW'(rem_shift);
            div_quo_in = {div_quo_ff[SUM_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + DCW'(1);
            if (div_cnt_ff == DCW'(SUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_item_in.score  = (|div_quo_ff[SUM_W-1:SUM_W-8]) ? '1 :
                                    div_quo_ff[SUM_W-9:SUM_W-8-SCORE_W];
               rsp_item_in.status = status_hold_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ranks_ff    <= NUM_RANKS_RESET;
         num_teams_ff    <= NUM_TEAMS_RESET;
         row_count_ff    <= '0;
         team_count_ff   <= '0;
         running_prob_ff <= '0;
         rank_reached_ff <= 1'b0;
         score_sum_ff    <= '0;
         max_rank_ff     <= '0;
         div_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         num_ranks_ff    <= num_ranks_in;
         num_teams_ff    <= num_teams_in;
         row_count_ff    <= row_count_in;
         team_count_ff   <= team_count_in;
         running_prob_ff <= running_prob_in;
         rank_reached_ff <= rank_reached_in;
         score_sum_ff    <= score_sum_in;
         max_rank_ff     <= max_rank_in;
         div_cnt_ff      <= div_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      weight_ff      <= weight_in;
      sq_ff          <= sq_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      div_quo_ff     <= div_quo_in;
      div_rem_ff     <= div_rem_in;
      divisor_ff     <= divisor_in;
      status_hold_ff <= status_hold_in;
      rsp_item_ff    <= rsp_item_in;
   end

   `ASSERT_PROP(a_row_item_starts_mul, (req_take && !last_row) |=> (state_ff == ST_SQ), "row item did not start the multiply sequence")
   `ASSERT_PROP(a_column_start_clear, (state_ff == ST_IDLE && row_count_ff == '0) |-> (running_prob_ff == '0 && !rank_reached_ff), "column start with stale cumulative state")
   `ASSERT_PROP(a_div_stays, (state_ff == ST_DIV) |=> (state_ff == ST_DIV || state_ff == ST_DONE), "divide left early")
   `ASSERT_PROP(a_rsp_from_done, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE), "result raised outside the final step")

endmodule
